FILE: rtl/ssbf_pkg.sv
package ssbf_pkg;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_XFER  = 2'd0,
        CMD_PUT   = 2'd1,
        CMD_GET   = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  miso_byte;
        logic [BYTE_W-1:0]  read_byte;
        logic [COUNT_W-1:0] rx_count;
        logic               rx_dropped;
        logic               tx_dropped;
        logic               rx_empty;
    } res_t;

endpackage

FILE: rtl/ssbf_ram.sv
module ssbf_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ssbf_pkg::BYTE_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [ssbf_pkg::BYTE_W-1:0] rd_data
);

    logic [ssbf_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [ssbf_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/spi_slave_byte_fifo_core.sv
// byte side of an spi slave with a receive ring and a transmit ring
//
// input channel s_*: one item per command in s_cmd (transfer done, put
// transmit byte, get received byte, flush receive ring) with s_data
// result channel m_*: exactly one item per input item, in order
//
// an item that needs no ring read (store, queue, drop, flush, empty get,
// transfer done with an empty transmit ring) is answered at the edge it is
// taken: its result shows on m_* in the cycle after acceptance
// an item that pops a byte (get, or transfer done with queued transmit
// data) reads the ring memory, whose read data is registered, so its
// result passes the read state, then the output register, with input held
// off in that state; one item per cycle holds only without pops or stalls
//
// each ring keeps one slot free and holds depth minus one bytes
// reset empties both rings and the shift register; ring contents are not
// cleared, no clearing pass is needed
// while m_ready is low the result stays in the output register; one new
// item may still be taken only when that register drains in the same cycle
module spi_slave_byte_fifo_core #(
    parameter int RX_DEPTH = 32,
    parameter int TX_DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ssbf_pkg::CMD_W-1:0]   s_cmd,
    input  logic [ssbf_pkg::BYTE_W-1:0]  s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ssbf_pkg::BYTE_W-1:0]  m_miso_byte,
    output logic [ssbf_pkg::BYTE_W-1:0]  m_read_byte,
    output logic [ssbf_pkg::COUNT_W-1:0] m_rx_count,
    output logic                         m_rx_dropped,
    output logic                         m_tx_dropped,
    output logic                         m_rx_empty
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int CW    = RX_AW + 1;
    localparam int CXW   = CW + ssbf_pkg::COUNT_W;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t                      state_reg, state_next;
    logic [RX_AW-1:0]            rx_head_reg, rx_head_next;
    logic [RX_AW-1:0]            rx_tail_reg, rx_tail_next;
    logic [TX_AW-1:0]            tx_head_reg, tx_head_next;
    logic [TX_AW-1:0]            tx_tail_reg, tx_tail_next;
    logic [ssbf_pkg::BYTE_W-1:0] shift_byte_reg, shift_byte_next;
    logic                        shift_loaded_reg, shift_loaded_next;
    logic                        m_valid_reg, m_valid_next;
    ssbf_pkg::res_t              res_reg, res_next;
    ssbf_pkg::res_t              pend_res_reg, pend_res_next;
    logic                        pend_tx_reg, pend_tx_next;

    logic [RX_AW-1:0]            rx_head_inc, rx_tail_inc;
    logic [TX_AW-1:0]            tx_head_inc, tx_tail_inc;
    logic                        rx_we, tx_we;
    logic [RX_AW-1:0]            rx_waddr;
    logic [TX_AW-1:0]            tx_waddr;
    logic [ssbf_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;
    logic                        accept, read_rx, read_tx;
    logic [CW-1:0]               cnt;
    logic [CXW-1:0]              cnt_ext;
    ssbf_pkg::res_t              res_cur;

    assign rx_head_inc = (rx_head_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_reg + 1'b1;
    assign rx_tail_inc = (rx_tail_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_reg + 1'b1;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    ssbf_ram #(
        .DEPTH (RX_DEPTH),
        .AW    (RX_AW)
    ) u_rx_ram (
        .aclk    (aclk),
        .wr_en   (rx_we),
        .wr_addr (rx_waddr),
        .wr_data (s_data),
        .rd_addr (rx_tail_inc),
        .rd_data (rx_rdata)
    );

    ssbf_ram #(
        .DEPTH (TX_DEPTH),
        .AW    (TX_AW)
    ) u_tx_ram (
        .aclk    (aclk),
        .wr_en   (tx_we),
        .wr_addr (tx_waddr),
        .wr_data (s_data),
        .rd_addr (tx_tail_inc),
        .rd_data (tx_rdata)
    );

    always_comb begin
        state_next        = state_reg;
        rx_head_next      = rx_head_reg;
        rx_tail_next      = rx_tail_reg;
        tx_head_next      = tx_head_reg;
        tx_tail_next      = tx_tail_reg;
        shift_byte_next   = shift_byte_reg;
        shift_loaded_next = shift_loaded_reg;
        m_valid_next      = m_valid_reg;
        res_next          = res_reg;
        pend_res_next     = pend_res_reg;
        pend_tx_next      = pend_tx_reg;
        rx_we             = 1'b0;
        tx_we             = 1'b0;
        rx_waddr          = rx_head_inc;
        tx_waddr          = tx_head_inc;
        read_rx           = 1'b0;
        read_tx           = 1'b0;
        res_cur           = '0;
        cnt               = '0;
        cnt_ext           = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (ssbf_pkg::cmd_t'(s_cmd))
                        ssbf_pkg::CMD_XFER: begin
                            if (rx_head_inc == rx_tail_reg) begin
                                res_cur.rx_dropped = 1'b1;
                            end else begin
                                rx_head_next = rx_head_inc;
                                rx_we        = 1'b1;
                            end
                            if (tx_head_reg != tx_tail_reg) begin
                                tx_tail_next      = tx_tail_inc;
                                shift_loaded_next = 1'b1;
                                read_tx           = 1'b1;
                            end else begin
                                shift_byte_next   = '0;
                                shift_loaded_next = 1'b0;
                            end
                        end
                        ssbf_pkg::CMD_PUT: begin
                            if (tx_head_reg == tx_tail_reg && !shift_loaded_reg) begin
                                shift_byte_next   = s_data;
                                shift_loaded_next = 1'b1;
                            end else if (tx_head_inc != tx_tail_reg) begin
                                tx_we        = 1'b1;
                                tx_head_next = tx_head_inc;
                            end else begin
                                res_cur.tx_dropped = 1'b1;
                            end
                        end
                        ssbf_pkg::CMD_GET: begin
                            if (rx_head_reg == rx_tail_reg) begin
                                res_cur.rx_empty = 1'b1;
                            end else begin
                                rx_tail_next = rx_tail_inc;
                                read_rx      = 1'b1;
                            end
                        end
                        ssbf_pkg::CMD_FLUSH: begin
                            rx_head_next = rx_tail_reg;
                        end
                        default: begin
                        end
                    endcase
                    // receive count from the indices after the step
                    if (rx_head_next >= rx_tail_next) begin
                        cnt = CW'(rx_head_next) - CW'(rx_tail_next);
                    end else begin
                        cnt = CW'(RX_DEPTH) - CW'(rx_tail_next) + CW'(rx_head_next);
                    end
                    cnt_ext           = CXW'(cnt);
                    res_cur.miso_byte = shift_byte_next;
                    res_cur.rx_count  = cnt_ext[ssbf_pkg::COUNT_W-1:0];
                    if (read_rx || read_tx) begin
                        pend_res_next = res_cur;
                        pend_tx_next  = read_tx;
                        state_next    = ST_READ;
                    end else begin
                        res_next     = res_cur;
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_READ: begin
                res_next = pend_res_reg;
                if (pend_tx_reg) begin
                    shift_byte_next    = tx_rdata;
                    res_next.miso_byte = tx_rdata;
                end else begin
                    res_next.read_byte = rx_rdata;
                end
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            rx_head_reg      <= '0;
            rx_tail_reg      <= '0;
            tx_head_reg      <= '0;
            tx_tail_reg      <= '0;
            shift_byte_reg   <= '0;
            shift_loaded_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            rx_head_reg      <= rx_head_next;
            rx_tail_reg      <= rx_tail_next;
            tx_head_reg      <= tx_head_next;
            tx_tail_reg      <= tx_tail_next;
            shift_byte_reg   <= shift_byte_next;
            shift_loaded_reg <= shift_loaded_next;
            m_valid_reg      <= m_valid_next;
        end
        res_reg      <= res_next;
        pend_res_reg <= pend_res_next;
        pend_tx_reg  <= pend_tx_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_miso_byte  = res_reg.miso_byte;
    assign m_read_byte  = res_reg.read_byte;
    assign m_rx_count   = res_reg.rx_count;
    assign m_rx_dropped = res_reg.rx_dropped;
    assign m_tx_dropped = res_reg.tx_dropped;
    assign m_rx_empty   = res_reg.rx_empty;

endmodule

FILE: tb/spi_slave_byte_fifo_core_checker.sv
`timescale 1ns / 1ps

module spi_slave_byte_fifo_core_checker #(
    parameter int RX_DEPTH = 32,
    parameter int TX_DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [ssbf_pkg::CMD_W-1:0]   s_cmd,
    input  logic [ssbf_pkg::BYTE_W-1:0]  s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [ssbf_pkg::BYTE_W-1:0]  m_miso_byte,
    input  logic [ssbf_pkg::BYTE_W-1:0]  m_read_byte,
    input  logic [ssbf_pkg::COUNT_W-1:0] m_rx_count,
    input  logic                         m_rx_dropped,
    input  logic                         m_tx_dropped,
    input  logic                         m_rx_empty,
    output int                           errors,
    output int                           pending,
    output int                           checked,
    output int                           rx_overflows,
    output int                           tx_drops,
    output int                           empty_gets
);

    localparam int MAX_PRINTED = 20;
    localparam int RX_AW       = $clog2(RX_DEPTH);
    localparam int TX_AW       = $clog2(TX_DEPTH);
    localparam int BW          = ssbf_pkg::BYTE_W;

    logic [BW-1:0]     rx_ring [RX_DEPTH];
    logic [BW-1:0]     tx_ring [TX_DEPTH];
    int                rx_head;
    int                rx_tail;
    int                tx_head;
    int                tx_tail;
    logic [BW-1:0]     shift_q;
    logic              shift_full;
    ssbf_pkg::res_t    expected_results [$];
    int                fail_count = 0;
    int                n_checked = 0;
    int                n_rx_ovf = 0;
    int                n_tx_drop = 0;
    int                n_empty = 0;

    initial begin
        errors       = 0;
        pending      = 0;
        checked      = 0;
        rx_overflows = 0;
        tx_drops     = 0;
        empty_gets   = 0;
    end

    function automatic int ring_next(input int idx, input int depth);
        return (idx + 1 >= depth) ? 0 : idx + 1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED) begin
            $display("%0t ns: %s", $time, msg);
        end
        fail_count = fail_count + 1;
    endtask

    task automatic check_field(input string name, input logic [BW-1:0] got,
                               input logic [BW-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      n_checked, name, got, want));
        end
    endtask

    task automatic step_fifo(input ssbf_pkg::cmd_t c, input logic [BW-1:0] d,
                             output ssbf_pkg::res_t r);
        int nxt;
        int cnt;
        r = '0;
        case (c)
            ssbf_pkg::CMD_XFER: begin
                nxt = ring_next(rx_head, RX_DEPTH);
                if (nxt == rx_tail) begin
                    r.rx_dropped = 1'b1;
                    n_rx_ovf = n_rx_ovf + 1;
                end else begin
                    rx_head                = nxt;
                    rx_ring[RX_AW'(nxt)]   = d;
                end
                if (tx_head != tx_tail) begin
                    tx_tail    = ring_next(tx_tail, TX_DEPTH);
                    shift_q    = tx_ring[TX_AW'(tx_tail)];
                    shift_full = 1'b1;
                end else begin
                    shift_q    = '0;
                    shift_full = 1'b0;
                end
            end
            ssbf_pkg::CMD_PUT: begin
                nxt = ring_next(tx_head, TX_DEPTH);
                if (tx_head == tx_tail && !shift_full) begin
                    shift_q    = d;
                    shift_full = 1'b1;
                end else if (nxt != tx_tail) begin
                    tx_ring[TX_AW'(nxt)] = d;
                    tx_head              = nxt;
                end else begin
                    r.tx_dropped = 1'b1;
                    n_tx_drop = n_tx_drop + 1;
                end
            end
            ssbf_pkg::CMD_GET: begin
                if (rx_head == rx_tail) begin
                    r.rx_empty = 1'b1;
                    n_empty = n_empty + 1;
                end else begin
                    rx_tail     = ring_next(rx_tail, RX_DEPTH);
                    r.read_byte = rx_ring[RX_AW'(rx_tail)];
                end
            end
            default: begin
                rx_head = rx_tail;
            end
        endcase
        cnt = (rx_head >= rx_tail) ? rx_head - rx_tail : RX_DEPTH - rx_tail + rx_head;
        r.miso_byte = shift_q;
        r.rx_count  = ssbf_pkg::COUNT_W'(cnt);
    endtask

    always @(posedge aclk) begin : watch
        ssbf_pkg::res_t want;
        if (!aresetn) begin
            rx_head    = 0;
            rx_tail    = 0;
            tx_head    = 0;
            tx_tail    = 0;
            shift_q    = '0;
            shift_full = 1'b0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("miso_byte", m_miso_byte, want.miso_byte);
                    check_field("read_byte", m_read_byte, want.read_byte);
                    check_field("rx_count", BW'(m_rx_count), BW'(want.rx_count));
                    check_field("rx_dropped", BW'(m_rx_dropped), BW'(want.rx_dropped));
                    check_field("tx_dropped", BW'(m_tx_dropped), BW'(want.tx_dropped));
                    check_field("rx_empty", BW'(m_rx_empty), BW'(want.rx_empty));
                    n_checked = n_checked + 1;
                end
            end
            if (s_valid && s_ready) begin
                step_fifo(ssbf_pkg::cmd_t'(s_cmd), s_data, want);
                expected_results.push_back(want);
            end
        end
        errors       <= fail_count;
        pending      <= expected_results.size();
        checked      <= n_checked;
        rx_overflows <= n_rx_ovf;
        tx_drops     <= n_tx_drop;
        empty_gets   <= n_empty;
    end

endmodule

FILE: tb/tb_spi_slave_byte_fifo_core.sv
`timescale 1ns / 1ps

module tb_spi_slave_byte_fifo_core;

    localparam int RX_DEPTH    = 32;
    localparam int TX_DEPTH    = 32;
    localparam int RAND_ITEMS  = 850;
    localparam int HOLD_CYCLES = 150;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [ssbf_pkg::CMD_W-1:0]   s_cmd;
    logic [ssbf_pkg::BYTE_W-1:0]  s_data;
    logic                         m_valid;
    logic                         m_ready;
    logic [ssbf_pkg::BYTE_W-1:0]  m_miso_byte;
    logic [ssbf_pkg::BYTE_W-1:0]  m_read_byte;
    logic [ssbf_pkg::COUNT_W-1:0] m_rx_count;
    logic                         m_rx_dropped;
    logic                         m_tx_dropped;
    logic                         m_rx_empty;
    logic                         hold_off_req;

    int errors;
    int pending;
    int checked;
    int rx_overflows;
    int tx_drops;
    int empty_gets;
    int sent_by_cmd [4] = '{0, 0, 0, 0};

    spi_slave_byte_fifo_core #(
        .RX_DEPTH(RX_DEPTH),
        .TX_DEPTH(TX_DEPTH)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_miso_byte (m_miso_byte),
        .m_read_byte (m_read_byte),
        .m_rx_count  (m_rx_count),
        .m_rx_dropped(m_rx_dropped),
        .m_tx_dropped(m_tx_dropped),
        .m_rx_empty  (m_rx_empty)
    );

    spi_slave_byte_fifo_core_checker #(
        .RX_DEPTH(RX_DEPTH),
        .TX_DEPTH(TX_DEPTH)
    ) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_miso_byte (m_miso_byte),
        .m_read_byte (m_read_byte),
        .m_rx_count  (m_rx_count),
        .m_rx_dropped(m_rx_dropped),
        .m_tx_dropped(m_tx_dropped),
        .m_rx_empty  (m_rx_empty),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .rx_overflows(rx_overflows),
        .tx_drops    (tx_drops),
        .empty_gets  (empty_gets)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("[spi_slave_byte_fifo_core] ERROR");
        $finish;
    end

    task automatic send_item(input ssbf_pkg::cmd_t c, input logic [ssbf_pkg::BYTE_W-1:0] d);
        s_valid <= 1'b1;
        s_cmd   <= c;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        sent_by_cmd[int'(c)] = sent_by_cmd[int'(c)] + 1;
    endtask

    task automatic pause_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic ssbf_pkg::cmd_t pick_cmd(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            1:       return (r < 90) ? ssbf_pkg::CMD_XFER
                                     : ((r < 95) ? ssbf_pkg::CMD_PUT : ssbf_pkg::CMD_GET);
            2:       return (r < 80) ? ssbf_pkg::CMD_GET
                                     : ((r < 95) ? ssbf_pkg::CMD_XFER : ssbf_pkg::CMD_PUT);
            3:       return (r < 88) ? ssbf_pkg::CMD_PUT
                                     : ((r < 94) ? ssbf_pkg::CMD_GET : ssbf_pkg::CMD_XFER);
            4:       return (r < 45) ? ssbf_pkg::CMD_XFER
                                     : ((r < 90) ? ssbf_pkg::CMD_PUT : ssbf_pkg::CMD_FLUSH);
            default: return ssbf_pkg::cmd_t'($urandom_range(0, 3));
        endcase
    endfunction

    // receiver: stretches of steady, random, mostly-ready and mostly-stalled ready
    initial begin : receiver
        int  stretch;
        int  style;
        bit  held;
        held = 1'b0;
        m_ready <= 1'b0;
        forever begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(5, 60);
            repeat (stretch) begin
                @(posedge aclk);
                if (hold_off_req && !held) begin
                    held = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end else begin
                    case (style)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        2:       m_ready <= ($urandom_range(0, 3) != 0);
                        default: m_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        int             n_rand;
        int             mode;
        int             seq_len;
        int             burst_left;
        int             no_gap_left;
        bit             quiet;
        ssbf_pkg::cmd_t c;
        n_rand      = 0;
        burst_left  = $urandom_range(1, 20);
        no_gap_left = 0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_cmd        <= ssbf_pkg::CMD_XFER;
        s_data       <= '0;
        hold_off_req <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // edge cases: empty get, direct load, queued byte, zero reload, flush
        send_item(ssbf_pkg::CMD_GET, 8'hFF);
        send_item(ssbf_pkg::CMD_XFER, 8'h00);
        send_item(ssbf_pkg::CMD_XFER, 8'hFF);
        send_item(ssbf_pkg::CMD_PUT, 8'hA5);
        send_item(ssbf_pkg::CMD_PUT, 8'h5A);
        send_item(ssbf_pkg::CMD_XFER, 8'h3C);
        send_item(ssbf_pkg::CMD_XFER, 8'hC3);
        send_item(ssbf_pkg::CMD_PUT, 8'h81);
        send_item(ssbf_pkg::CMD_PUT, 8'h7E);
        send_item(ssbf_pkg::CMD_GET, 8'h00);
        send_item(ssbf_pkg::CMD_GET, 8'h55);
        send_item(ssbf_pkg::CMD_GET, 8'hAA);
        send_item(ssbf_pkg::CMD_FLUSH, 8'hFF);
        send_item(ssbf_pkg::CMD_GET, 8'h00);
        send_item(ssbf_pkg::CMD_FLUSH, 8'h00);
        send_item(ssbf_pkg::CMD_XFER, 8'h01);
        send_item(ssbf_pkg::CMD_XFER, 8'h80);
        send_item(ssbf_pkg::CMD_GET, 8'h00);
        send_item(ssbf_pkg::CMD_GET, 8'h00);
        send_item(ssbf_pkg::CMD_GET, 8'h00);

        while (n_rand < RAND_ITEMS) begin
            mode    = $urandom_range(0, 4);
            seq_len = $urandom_range(8, 45);
            quiet   = ($urandom_range(0, 3) == 0);
            repeat (seq_len) begin
                c = pick_cmd(mode);
                send_item(c, 8'($urandom_range(0, 255)));
                n_rand = n_rand + 1;
                if (n_rand == 300) begin
                    hold_off_req <= 1'b1;
                    no_gap_left = 40;
                end
                if (n_rand == 600) begin
                    drain_results();
                end
                if (no_gap_left > 0) begin
                    no_gap_left = no_gap_left - 1;
                end else if (!quiet) begin
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        pause_sender($urandom_range(1, 6));
                        burst_left = $urandom_range(1, 20);
                    end
                end
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        $display("covered %0d transfers, %0d puts, %0d gets, %0d flushes; %0d results checked",
                 sent_by_cmd[0], sent_by_cmd[1], sent_by_cmd[2], sent_by_cmd[3], checked);
        $display("receive overflows %0d, transmit drops %0d, gets on empty ring %0d",
                 rx_overflows, tx_drops, empty_gets);
        if (errors == 0) begin
            $display("[spi_slave_byte_fifo_core] OK");
        end else begin
            $display("[spi_slave_byte_fifo_core] ERROR");
        end
        $finish;
    end

endmodule
